### hw/rtl/kewa_pkg.sv
package kewa_pkg;

    localparam int MAX_WORD = 32;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int IDX_W    = $clog2(MAX_WORD);
    localparam int CHAR_W   = 7;
    localparam int CODE_W   = 8;
    localparam int LIM_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW  = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_WORD_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT = 2'd1;
    localparam logic [LIM_W-1:0]     LIMIT_RESET     = 6'd32;

    localparam logic [CODE_W-1:0] KEY_BACK   = 8'h08;
    localparam logic [CODE_W-1:0] KEY_ESCAPE = 8'h1B;
    localparam logic [CODE_W-1:0] KEY_A      = 8'h41;
    localparam logic [CODE_W-1:0] KEY_Z      = 8'h5A;
    localparam logic [CODE_W-1:0] KEY_0      = 8'h30;
    localparam logic [CODE_W-1:0] KEY_9      = 8'h39;
    localparam logic [CODE_W-1:0] CASE_OFS   = 8'h20;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_BACK   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_EMIT   = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic [LEN_W-1:0] len;
        logic             cmd_pop;
    } t_back_status;

    function automatic logic is_boundary(input logic [CODE_W-1:0] code);
        logic r;
        unique case (code)
            8'h20, 8'h0D, 8'h09, 8'hBC, 8'hBE, 8'hBF, 8'hBA,
            8'hDE, 8'hDB, 8'hDD, 8'hDC, 8'hC0, 8'hBD, 8'hBB: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_modifier(input logic [CODE_W-1:0] code);
        logic r;
        unique case (code)
            8'h10, 8'h11, 8'h12, 8'h14, 8'h5B, 8'h5C,
            8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/kewa_front.sv
module kewa_front
    import kewa_pkg::*;
(
    input  logic              i_push,
    input  logic              i_fifo_full,
    input  logic [CODE_W-1:0] i_key_code,
    input  logic              i_key_up,
    input  logic              i_shift_held,
    output logic              o_wr,
    output t_cmd              o_cmd
);

    logic              keep;
    logic [CODE_W-1:0] lc;

    assign lc = i_key_code + CASE_OFS;

    always_comb begin
        keep     = 1'b0;
        o_cmd.op = OP_APPEND;
        o_cmd.ch = i_key_code[CHAR_W-1:0];
        if (i_key_up) begin
            keep = 1'b0;
        end else if (is_boundary(i_key_code)) begin
            keep     = 1'b1;
            o_cmd.op = OP_EMIT;
        end else if (is_modifier(i_key_code)) begin
            keep = 1'b0;
        end else if (i_key_code == KEY_BACK) begin
            keep     = 1'b1;
            o_cmd.op = OP_BACK;
        end else if (i_key_code == KEY_ESCAPE) begin
            keep     = 1'b1;
            o_cmd.op = OP_CLEAR;
        end else if (i_key_code >= KEY_A && i_key_code <= KEY_Z) begin
            keep     = 1'b1;
            o_cmd.ch = i_shift_held ? i_key_code[CHAR_W-1:0] : lc[CHAR_W-1:0];
        end else if (i_key_code >= KEY_0 && i_key_code <= KEY_9) begin
            keep = 1'b1;
        end
    end

    assign o_wr = i_push && !i_fifo_full && keep;

endmodule

### hw/rtl/kewa_cmd_fifo.sv
module kewa_cmd_fifo
    import kewa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    input  logic i_rd,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [FIFO_AW:0] r_wp, r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp[FIFO_AW-1:0]] <= i_cmd;
    end

    assign o_cmd   = r_mem[r_rp[FIFO_AW-1:0]];
    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[FIFO_AW] != r_rp[FIFO_AW])
                  && (r_wp[FIFO_AW-1:0] == r_rp[FIFO_AW-1:0]);

endmodule

### hw/rtl/kewa_back.sv
module kewa_back
    import kewa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LIM_W-1:0]  i_word_limit,
    input  logic [LIM_W-1:0]  i_event_limit,
    input  logic              i_cmd_empty,
    input  t_cmd              i_cmd,
    input  logic              i_pop,
    output t_back_status      o_status,
    output logic              o_empty,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last,
    output logic              o_cause
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [CHAR_W-1:0] r_mem [MAX_WORD];
    logic [CHAR_W-1:0] r_rdata;

    logic [1:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_cause, n_cause;
    logic              r_pend, n_pend;
    logic [CHAR_W-1:0] r_pch, n_pch;

    logic              r_ov, n_ov;
    logic [CHAR_W-1:0] r_och, n_och;
    logic              r_olast, n_olast;
    logic              r_ocause, n_ocause;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CHAR_W-1:0] wdata;
    logic              cmd_pop;
    logic [LIM_W-1:0]  lim_min;
    logic [LEN_W-1:0]  lim;
    logic              slot_free;
    logic              is_last;

    always_comb begin
        lim_min = (i_word_limit < i_event_limit) ? i_word_limit : i_event_limit;
        if (LEN_W'(lim_min) > LEN_W'(MAX_WORD)) lim = LEN_W'(MAX_WORD);
        else                                    lim = LEN_W'(lim_min);
    end

    assign slot_free = !r_ov || i_pop;
    assign is_last   = (LEN_W'(r_idx) == r_cnt - 1'b1);

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_cause  = r_cause;
        n_pend   = r_pend;
        n_pch    = r_pch;
        n_ov     = r_ov && !i_pop;
        n_och    = r_och;
        n_olast  = r_olast;
        n_ocause = r_ocause;
        we       = 1'b0;
        waddr    = r_len[IDX_W-1:0];
        wdata    = i_cmd.ch;
        cmd_pop  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_APPEND: begin
                            if (r_len >= lim && r_len != '0) begin
                                n_idx   = '0;
                                n_cnt   = r_len;
                                n_cause = 1'b1;
                                n_pend  = 1'b1;
                                n_pch   = i_cmd.ch;
                                n_state = S_RD;
                            end else if (r_len < LEN_W'(MAX_WORD)) begin
                                we    = 1'b1;
                                n_len = r_len + 1'b1;
                            end
                        end
                        OP_BACK: begin
                            if (r_len != '0) n_len = r_len - 1'b1;
                        end
                        OP_CLEAR: begin
                            n_len = '0;
                        end
                        OP_EMIT: begin
                            if (r_len != '0) begin
                                n_idx   = '0;
                                n_cnt   = r_len;
                                n_cause = 1'b0;
                                n_pend  = 1'b0;
                                n_state = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_ov     = 1'b1;
                    n_och    = r_rdata;
                    n_olast  = is_last;
                    n_ocause = r_cause;
                    if (is_last) begin
                        n_state = S_IDLE;
                        if (r_pend) begin
                            we    = 1'b1;
                            waddr = '0;
                            wdata = r_pch;
                            n_len = LEN_W'(1);
                        end else begin
                            n_len = '0;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_cause  <= n_cause;
        r_pend   <= n_pend;
        r_pch    <= n_pch;
        r_och    <= n_och;
        r_olast  <= n_olast;
        r_ocause <= n_ocause;
    end

    // word store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[r_idx];
    end

    assign o_status.busy    = (r_state != S_IDLE);
    assign o_status.len     = r_len;
    assign o_status.cmd_pop = cmd_pop;

    assign o_empty     = !r_ov;
    assign o_char_code = r_och;
    assign o_last      = r_olast;
    assign o_cause     = r_ocause;

endmodule

### hw/rtl/key_event_word_assembler.sv
// Key event word assembler. Key events enter through a queue port (push/full),
// are classified in the same cycle and parked in a four-entry command queue;
// releases, modifiers and unknown keys leave no trace. The back end runs one
// command per cycle while no flush is in progress. A flush (boundary key, or
// a character arriving with the word at its limit) reads the word store one
// character per beat through the single registered read port; each beat has a
// read state then an output state, which stalls while the output is full and
// the consumer holds pop low. Results leave through an output register
// (empty/pop); each beat carries one character, a last mark on the final one
// and the cause of the flush. The effective length limit is the smaller of
// the two limit registers, saturated at 32; write them only while idle.
module key_event_word_assembler
    import kewa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIM_W-1:0]     i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [CODE_W-1:0]    i_key_code,
    input  logic                 i_key_up,
    input  logic                 i_shift_held,
    output logic                 empty,
    input  logic                 pop,
    output logic [CHAR_W-1:0]    o_char_code,
    output logic                 o_last,
    output logic                 o_cause
);

    logic [LIM_W-1:0] r_word_limit, r_event_limit;
    logic             fifo_wr, fifo_full, fifo_empty;
    t_cmd             wr_cmd, rd_cmd;
    t_back_status     bst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_limit  <= LIMIT_RESET;
            r_event_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WORD_LIMIT)  r_word_limit  <= i_cfg_data;
            if (i_cfg_idx == REG_EVENT_LIMIT) r_event_limit <= i_cfg_data;
        end
    end

    assign full = fifo_full;

    kewa_front u_front (
        .i_push       (push),
        .i_fifo_full  (fifo_full),
        .i_key_code   (i_key_code),
        .i_key_up     (i_key_up),
        .i_shift_held (i_shift_held),
        .o_wr         (fifo_wr),
        .o_cmd        (wr_cmd)
    );

    kewa_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_cmd   (wr_cmd),
        .i_rd    (bst.cmd_pop),
        .o_cmd   (rd_cmd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    kewa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word_limit  (r_word_limit),
        .i_event_limit (r_event_limit),
        .i_cmd_empty   (fifo_empty),
        .i_cmd         (rd_cmd),
        .i_pop         (pop),
        .o_status      (bst),
        .o_empty       (empty),
        .o_char_code   (o_char_code),
        .o_last        (o_last),
        .o_cause       (o_cause)
    );

`ifndef NO_ASSERTIONS
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bst.len <= LEN_W'(MAX_WORD))
        else $error("word length above maximum");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bst.cmd_pop |-> !fifo_empty && !bst.busy)
        else $error("command taken from empty queue or while flushing");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_wr |-> !fifo_full)
        else $error("command queue overrun");

    a_flush_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bst.busy && !$past(bst.busy) |-> $past(bst.len) != '0)
        else $error("flush started on an empty word");
`endif

endmodule
